// ===== hw/rtl/bfra_pkg.sv =====
// ----------------------------------------------------------------------------
// bfra_pkg
// Shared types and constants of the best-fit region allocator.
// ----------------------------------------------------------------------------
package bfra_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int COUNT_OUT_W     = 7;

    localparam logic [31:0] KIND_FREE = 32'd1;
    localparam logic [31:0] KIND_USED = 32'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] region_base;
        logic [63:0] region_length;
        logic [31:0] region_kind;
        logic [31:0] region_acpi;
        logic [63:0] request_size;
        logic [31:0] release_address;
    } t_in_word;

    typedef struct packed {
        logic [31:0]            granted_address;
        logic [1:0]             status;
        logic [COUNT_OUT_W-1:0] region_count;
    } t_out_word;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] length;
        logic [31:0] kind;
        logic [31:0] acpi;
    } t_entry;

    typedef enum logic [2:0] {
        CMD_IDLE    = 3'd0,
        CMD_LOAD    = 3'd1,
        CMD_MARK    = 3'd2,
        CMD_SPLIT   = 3'd3,
        CMD_MERGE_L = 3'd4,
        CMD_MERGE_R = 3'd5
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic        split;
        logic        is_free;
        logic [63:0] size;
        logic [31:0] addr;
        t_entry      load;
    } t_cell_cmd;

    typedef struct packed {
        logic        found;
        logic [63:0] base;
        logic [63:0] length;
    } t_scan;

endpackage

// ===== hw/rtl/bfra_if.sv =====
// ----------------------------------------------------------------------------
// bfra_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface bfra_in_if;
    import bfra_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfra_out_if;
    import bfra_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bfra_cell.sv =====
// ----------------------------------------------------------------------------
// bfra_cell
// One table slot: holds a region, shifts with its neighbors, and takes part
// in the registered best-fit / first-match search chain.
// ----------------------------------------------------------------------------
module bfra_cell #(
    parameter int MAX_REGIONS = 64,
    parameter int IDX         = 0
) (
    input  logic                               i_clk,
    input  bfra_pkg::t_cell_cmd                i_cmd,
    input  logic [$clog2(MAX_REGIONS)-1:0]     i_pos,
    input  logic [$clog2(MAX_REGIONS+1)-1:0]   i_count,
    input  bfra_pkg::t_entry                   i_left,
    input  bfra_pkg::t_entry                   i_right,
    output bfra_pkg::t_entry                   o_entry,
    input  bfra_pkg::t_scan                    i_scan,
    input  logic [$clog2(MAX_REGIONS)-1:0]     i_scan_idx,
    output bfra_pkg::t_scan                    o_scan,
    output logic [$clog2(MAX_REGIONS)-1:0]     o_scan_idx,
    output logic                               o_hit_l,
    output logic                               o_hit_r
);
    import bfra_pkg::*;

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    t_entry          r_e, n_e;
    t_scan           r_scan, n_scan;
    logic [IW-1:0]   r_sidx, n_sidx;
    logic [CW-1:0]   w_pos;
    logic            w_valid, w_rvalid, w_match, w_take;

    assign w_pos    = CW'(i_pos);
    assign w_valid  = MY_IDX < i_count;
    assign w_rvalid = (MY_IDX + CW'(1)) < i_count;

    always_comb begin
        n_e = r_e;
        unique case (i_cmd.op)
            CMD_LOAD: begin
                if (MY_IDX == i_count) n_e = i_cmd.load;
            end
            CMD_MARK: begin
                if (MY_IDX == w_pos) n_e.kind = KIND_FREE;
            end
            CMD_SPLIT: begin
                if (MY_IDX == w_pos) begin
                    n_e.length = i_cmd.size;
                    n_e.kind   = KIND_USED;
                end else if (i_cmd.split && MY_IDX == w_pos + CW'(1)) begin
                    n_e.base   = i_left.base + i_cmd.size;
                    n_e.length = i_left.length - i_cmd.size;
                    n_e.kind   = KIND_FREE;
                    n_e.acpi   = i_left.acpi;
                end else if (i_cmd.split && MY_IDX > w_pos + CW'(1)) begin
                    n_e = i_left;
                end
            end
            CMD_MERGE_L: begin
                if (MY_IDX + CW'(1) == w_pos) n_e.length = r_e.length + i_right.length;
                else if (MY_IDX >= w_pos) n_e = i_right;
            end
            CMD_MERGE_R: begin
                if (MY_IDX == w_pos) n_e.length = r_e.length + i_right.length;
                else if (MY_IDX > w_pos) n_e = i_right;
            end
            default: n_e = r_e;
        endcase
    end

    // search step
    always_comb begin
        if (i_cmd.is_free) begin
            w_match = w_valid && (r_e.base == {32'd0, i_cmd.addr});
            w_take  = w_match && !i_scan.found;
        end else begin
            w_match = w_valid && (r_e.base != 64'd0) && (r_e.kind == KIND_FREE)
                      && (r_e.length >= i_cmd.size);
            w_take  = w_match && (!i_scan.found || (i_scan.length > r_e.length));
        end
        n_scan = i_scan;
        n_sidx = i_scan_idx;
        if (w_take) begin
            n_scan.found  = 1'b1;
            n_scan.base   = r_e.base;
            n_scan.length = r_e.length;
            n_sidx        = IW'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_scan <= n_scan;
        r_sidx <= n_sidx;
    end

    assign o_hit_l = (MY_IDX == w_pos) && (i_left.kind == KIND_FREE)
                     && (i_left.base + i_left.length == r_e.base) && (MY_IDX != '0);
    assign o_hit_r = (MY_IDX == w_pos) && w_rvalid && (i_right.kind == KIND_FREE)
                     && (r_e.base + r_e.length == i_right.base);

    assign o_entry    = r_e;
    assign o_scan     = r_scan;
    assign o_scan_idx = r_sidx;

endmodule

// ===== hw/rtl/best_fit_region_allocator_top.sv =====
// ----------------------------------------------------------------------------
// best_fit_region_allocator_top
// Load: accept goes to S_DONE, which registers the response. Allocate and
// free: S_SCAN runs the registered search chain, one cell per cycle, then
// S_ALLOC or S_FMARK/S_FLEFT/S_FRGHT; one word in flight at a time. Reset
// clears the region count and the controller; table contents are not cleared.
// ----------------------------------------------------------------------------
module best_fit_region_allocator_top #(
    parameter int MAX_REGIONS = bfra_pkg::MAX_REGIONS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bfra_in_if.sink        i_in,
    bfra_out_if.source     o_out
);
    import bfra_pkg::*;

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_REGIONS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_ALLOC = 7'b0000100,
        S_FMARK = 7'b0001000,
        S_FLEFT = 7'b0010000,
        S_FRGHT = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic [63:0]   r_size, n_size;
    logic [31:0]   r_addr, n_addr;
    logic [IW-1:0] r_pos, n_pos;
    logic          r_split, n_split;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_scnt, n_scnt;
    t_status       r_status, n_status;
    logic [31:0]   r_granted, n_granted;
    logic          r_ovalid, n_ovalid;
    t_out_word     r_odata, n_odata;

    t_cell_cmd     w_cmd;
    t_entry        w_entry [MAX_REGIONS];
    t_scan         w_scan  [MAX_REGIONS+1];
    logic [IW-1:0] w_sidx  [MAX_REGIONS+1];
    logic [MAX_REGIONS-1:0] w_hl, w_hr;
    logic          w_accept, w_hit_l, w_hit_r;
    logic [63:0]   w_rest;
    t_entry        w_zero;

    assign w_zero    = '0;
    assign w_scan[0] = '0;
    assign w_sidx[0] = '0;

    generate
        for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
            bfra_cell #(.MAX_REGIONS(MAX_REGIONS), .IDX(g)) u_cell (
                .i_clk      (i_clk),
                .i_cmd      (w_cmd),
                .i_pos      (r_pos),
                .i_count    (r_count),
                .i_left     ((g == 0) ? w_zero : w_entry[(g == 0) ? 0 : g-1]),
                .i_right    ((g == MAX_REGIONS-1) ? w_zero
                             : w_entry[(g == MAX_REGIONS-1) ? g : g+1]),
                .o_entry    (w_entry[g]),
                .i_scan     (w_scan[g]),
                .i_scan_idx (w_sidx[g]),
                .o_scan     (w_scan[g+1]),
                .o_scan_idx (w_sidx[g+1]),
                .o_hit_l    (w_hl[g]),
                .o_hit_r    (w_hr[g])
            );
        end
    endgenerate

    assign w_hit_l  = |w_hl;
    assign w_hit_r  = |w_hr;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_rest   = w_scan[MAX_REGIONS].length - r_size;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    always_comb begin
        w_cmd.op           = CMD_IDLE;
        w_cmd.split        = r_split;
        w_cmd.is_free      = (r_op == OP_FREE);
        w_cmd.size         = r_size;
        w_cmd.addr         = r_addr;
        w_cmd.load.base    = i_in.data.region_base;
        w_cmd.load.length  = i_in.data.region_length;
        w_cmd.load.kind    = i_in.data.region_kind;
        w_cmd.load.acpi    = i_in.data.region_acpi;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && t_op'(i_in.data.operation) == OP_LOAD && r_count < MAX_C)
                    w_cmd.op = CMD_LOAD;
            end
            S_ALLOC: w_cmd.op = CMD_SPLIT;
            S_FMARK: w_cmd.op = CMD_MARK;
            S_FLEFT: begin
                if (w_hit_l) w_cmd.op = CMD_MERGE_L;
            end
            S_FRGHT: begin
                if (w_hit_r) w_cmd.op = CMD_MERGE_R;
            end
            default: w_cmd.op = CMD_IDLE;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_size    = r_size;
        n_addr    = r_addr;
        n_pos     = r_pos;
        n_split   = r_split;
        n_count   = r_count;
        n_scnt    = r_scnt;
        n_status  = r_status;
        n_granted = r_granted;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        if (o_out.ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op      = t_op'(i_in.data.operation);
                    n_size    = i_in.data.request_size;
                    n_addr    = i_in.data.release_address;
                    n_scnt    = '0;
                    n_status  = ST_OK;
                    n_granted = '0;
                    unique case (t_op'(i_in.data.operation))
                        OP_LOAD: begin
                            n_state = S_DONE;
                            if (r_count < MAX_C) n_count = r_count + CW'(1);
                            else n_status = ST_FULL;
                        end
                        OP_ALLOC, OP_FREE: n_state = S_SCAN;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                n_scnt = r_scnt + CW'(1);
                if (r_scnt == MAX_C) begin
                    n_pos = w_sidx[MAX_REGIONS];
                    if (r_op == OP_FREE) begin
                        if (!w_scan[MAX_REGIONS].found) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_FMARK;
                        end
                    end else if (!w_scan[MAX_REGIONS].found) begin
                        n_status = ST_NO_FIT;
                        n_state  = S_DONE;
                    end else if (w_rest != 64'd0 && r_count >= MAX_C) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_split   = (w_rest != 64'd0);
                        n_granted = w_scan[MAX_REGIONS].base[31:0];
                        n_state   = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (r_split) n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_FMARK: n_state = S_FLEFT;
            S_FLEFT: begin
                if (w_hit_l) begin
                    n_count = r_count - CW'(1);
                    n_pos   = r_pos - IW'(1);
                end
                n_state = S_FRGHT;
            end
            S_FRGHT: begin
                if (w_hit_r) n_count = r_count - CW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid                = 1'b1;
                    n_odata.granted_address = r_granted;
                    n_odata.status          = r_status;
                    n_odata.region_count    = COUNT_OUT_W'(r_count);
                    n_state                 = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_op      <= n_op;
        r_size    <= n_size;
        r_addr    <= n_addr;
        r_pos     <= n_pos;
        r_split   <= n_split;
        r_scnt    <= n_scnt;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_odata   <= n_odata;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_C) else $error("region count above table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)
             || r_count + CW'(1) == $past(r_count)))
        else $error("region count jumped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE) else $error("idle right after accept");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odata.status != ST_OK) |-> r_odata.granted_address == 32'd0)
        else $error("grant on failed word");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the best-fit region allocator. Request words are
// driven over the input channel and response words are collected from the
// output channel, both with random idle cycles. A scoreboard keeps its own
// copy of the region table, predicts every response and compares it field
// by field. Directed words cover the corner cases, and random words grow,
// fill and churn the table.
// ----------------------------------------------------------------------------
class region_scoreboard;
    localparam int NREG = bfra_pkg::MAX_REGIONS_DEF;

    logic [63:0] rbase [NREG];
    logic [63:0] rlen  [NREG];
    logic [31:0] rkind [NREG];
    logic [31:0] racpi [NREG];
    int          cnt;
    bfra_pkg::t_out_word expected_q [$];
    int          errors;
    int          n_op [4];
    int          n_st [4];

    function new();
        cnt    = 0;
        errors = 0;
        foreach (n_op[i]) n_op[i] = 0;
        foreach (n_st[i]) n_st[i] = 0;
    endfunction

    function void copy_e(int d, int s);
        rbase[d] = rbase[s];
        rlen[d]  = rlen[s];
        rkind[d] = rkind[s];
        racpi[d] = racpi[s];
    endfunction

    function void remove_e(int pos);
        for (int k = pos; k + 1 < cnt; k++) copy_e(k, k + 1);
        cnt--;
    endfunction

    function bfra_pkg::t_status do_alloc(logic [63:0] size, output logic [31:0] granted);
        int          pick;
        bit          found;
        logic [63:0] rest;
        pick    = 0;
        found   = 0;
        granted = '0;
        for (int k = 0; k < cnt; k++) begin
            if (rbase[k] != 0 && rkind[k] == bfra_pkg::KIND_FREE && rlen[k] >= size) begin
                if (!found || rlen[pick] > rlen[k]) begin
                    pick  = k;
                    found = 1;
                end
            end
        end
        if (!found) return bfra_pkg::ST_NO_FIT;
        rest = rlen[pick] - size;
        if (rest != 0) begin
            if (cnt >= NREG) return bfra_pkg::ST_FULL;
            for (int k = cnt; k > pick; k--) copy_e(k, k - 1);
            rbase[pick+1] = rbase[pick] + size;
            rlen[pick+1]  = rest;
            rkind[pick+1] = bfra_pkg::KIND_FREE;
            racpi[pick+1] = racpi[pick];
            cnt++;
        end
        rlen[pick]  = size;
        rkind[pick] = bfra_pkg::KIND_USED;
        granted     = rbase[pick][31:0];
        return bfra_pkg::ST_OK;
    endfunction

    function bfra_pkg::t_status do_free(logic [63:0] addr);
        int pos;
        bit found;
        pos   = 0;
        found = 0;
        for (int k = 0; k < cnt; k++) begin
            if (!found && rbase[k] == addr) begin
                pos   = k;
                found = 1;
            end
        end
        if (!found) return bfra_pkg::ST_NOT_FOUND;
        rkind[pos] = bfra_pkg::KIND_FREE;
        if (pos > 0 && rkind[pos-1] == bfra_pkg::KIND_FREE &&
            rbase[pos-1] + rlen[pos-1] == rbase[pos]) begin
            rlen[pos-1] = rlen[pos-1] + rlen[pos];
            remove_e(pos);
            pos--;
        end
        if (pos + 1 < cnt && rkind[pos+1] == bfra_pkg::KIND_FREE &&
            rbase[pos] + rlen[pos] == rbase[pos+1]) begin
            rlen[pos] = rlen[pos] + rlen[pos+1];
            remove_e(pos + 1);
        end
        return bfra_pkg::ST_OK;
    endfunction

    function void note(bfra_pkg::t_in_word w);
        bfra_pkg::t_out_word e;
        bfra_pkg::t_status   st;
        logic [31:0]         g;
        g  = '0;
        st = bfra_pkg::ST_OK;
        case (bfra_pkg::t_op'(w.operation))
            bfra_pkg::OP_LOAD: begin
                if (cnt >= NREG) st = bfra_pkg::ST_FULL;
                else begin
                    rbase[cnt] = w.region_base;
                    rlen[cnt]  = w.region_length;
                    rkind[cnt] = w.region_kind;
                    racpi[cnt] = w.region_acpi;
                    cnt++;
                end
            end
            bfra_pkg::OP_ALLOC: st = do_alloc(w.request_size, g);
            bfra_pkg::OP_FREE:  st = do_free({32'd0, w.release_address});
            default: ;
        endcase
        n_op[w.operation]++;
        e.granted_address = g;
        e.status          = st;
        e.region_count    = cnt[bfra_pkg::COUNT_OUT_W-1:0];
        expected_q.push_back(e);
    endfunction

    function void check(bfra_pkg::t_out_word got);
        bfra_pkg::t_out_word e;
        if (expected_q.size() == 0) begin
            $error("response word with no expectation waiting: %h", got);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        n_st[e.status]++;
        if (got.granted_address !== e.granted_address) begin
            $error("granted_address: expected %h, actual %h", e.granted_address,
                   got.granted_address);
            errors++;
        end
        if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            errors++;
        end
        if (got.region_count !== e.region_count) begin
            $error("region_count: expected %0d, actual %0d", e.region_count,
                   got.region_count);
            errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfra_pkg::*;

    logic i_clk;
    logic i_rst_n;

    bfra_in_if  in_if ();
    bfra_out_if out_if ();

    best_fit_region_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    region_scoreboard sb = new();
    bit               no_idle;
    bit               hold_req;
    logic [63:0]      cursor;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check(out_if.data);
    end

    // response side: random stalls, one long hold when asked
    initial begin
        int n;
        out_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 3);
            if (hold_req) begin
                hold_req = 0;
                n = 400;
            end
            if (n > 0) begin
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    task automatic send(input t_in_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note(w);
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_in_word mk(t_op op, logic [63:0] b, logic [63:0] l,
                                    logic [31:0] k, logic [31:0] a,
                                    logic [63:0] sz, logic [31:0] ra);
        t_in_word w;
        w.operation       = op;
        w.region_base     = b;
        w.region_length   = l;
        w.region_kind     = k;
        w.region_acpi     = a;
        w.request_size    = sz;
        w.release_address = ra;
        return w;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_word rand_word(int load_pct);
        t_in_word    w;
        int          r;
        int          idx;
        logic [63:0] len;
        w = mk(OP_NONE, rnd64(), rnd64(), $urandom, $urandom, rnd64(), $urandom);
        r = $urandom_range(0, 99);
        if (r < 2) return w;
        if (r < 2 + load_pct) begin
            w.operation = OP_LOAD;
            if ($urandom_range(0, 19) != 0) begin
                len = $urandom_range(1, 'h400);
                if ($urandom_range(0, 4) == 0) cursor = cursor + $urandom_range(1, 'h100);
                w.region_base   = cursor;
                w.region_length = len;
                cursor          = cursor + len;
            end
            r = $urandom_range(0, 9);
            if (r < 8)      w.region_kind = KIND_FREE;
            else if (r < 9) w.region_kind = KIND_USED;
        end else if ($urandom_range(0, 1) == 0) begin
            w.operation = OP_ALLOC;
            r = $urandom_range(0, 9);
            if (r < 7) w.request_size = $urandom_range(0, 'h400);
            else if (r < 8) w.request_size = '0;
            else if (r < 9 && sb.cnt > 0) w.request_size = sb.rlen[$urandom_range(0, sb.cnt-1)];
        end else begin
            w.operation = OP_FREE;
            if ($urandom_range(0, 4) != 0 && sb.cnt > 0) begin
                idx = $urandom_range(0, sb.cnt - 1);
                w.release_address = sb.rbase[idx][31:0];
            end
        end
        return w;
    endfunction

    initial begin
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        i_rst_n     <= 1'b0;
        no_idle  = 0;
        hold_req = 0;
        cursor   = 64'h10000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases
        send(mk(OP_ALLOC, 0, 0, 0, 0, 64'h10, 0));
        send(mk(OP_FREE, 0, 0, 0, 0, 0, 32'h0));
        send(mk(OP_NONE, '1, '1, '1, '1, '1, '1));
        send(mk(OP_LOAD, 64'h0, 64'h800, KIND_FREE, 32'h0, 0, 0));
        send(mk(OP_LOAD, 64'h1000, 64'h100, KIND_FREE, 32'hFFFF_FFFF, 0, 0));
        send(mk(OP_LOAD, 64'h1100, 64'h100, KIND_FREE, 32'h1234_5678, 0, 0));
        send(mk(OP_LOAD, 64'h1200, 64'h40, KIND_USED, 32'h0, 0, 0));
        send(mk(OP_LOAD, '1, '1, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 0, 0));
        send(mk(OP_ALLOC, 0, 0, 0, 0, 64'h100, 0));
        send(mk(OP_ALLOC, 0, 0, 0, 0, 64'h0, 0));
        send(mk(OP_FREE, 0, 0, 0, 0, 0, 32'h1100));
        send(mk(OP_FREE, 0, 0, 0, 0, 0, 32'h1000));
        send(mk(OP_ALLOC, 0, 0, 0, 0, 64'h80, 0));
        send(mk(OP_ALLOC, 0, 0, 0, 0, '1, 0));
        send(mk(OP_LOAD, 64'h1_0000_0000, 64'h8, KIND_FREE, 32'h1, 0, 0));
        send(mk(OP_ALLOC, 0, 0, 0, 0, 64'h8, 0));
        send(mk(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, KIND_FREE, 32'h2, 0, 0));
        send(mk(OP_ALLOC, 0, 0, 0, 0, 64'h1C, 0));
        send(mk(OP_FREE, 0, 0, 0, 0, 0, 32'hFFFF_FFF0));
        send(mk(OP_FREE, 0, 0, 0, 0, 0, 32'hDEAD_BEEF));
        send(mk(OP_FREE, 0, 0, 0, 0, 0, 32'h1200));

        // growth until the table is full, then full-table loads and splits
        for (int i = 0; i < 450; i++) send(rand_word(55));

        // long response hold while requests keep coming
        hold_req = 1;
        for (int i = 0; i < 6; i++) send(rand_word(40));
        in_if.valid <= 1'b0;
        drain();

        // churn, with a stretch without idle cycles
        for (int i = 0; i < 870; i++) begin
            no_idle = (i >= 300 && i < 400);
            send(rand_word(i < 600 ? 30 : 45));
        end
        no_idle = 0;
        in_if.valid <= 1'b0;
        drain();

        $display("ran %0d loads, %0d allocates, %0d frees, %0d idle ops",
                 sb.n_op[OP_LOAD], sb.n_op[OP_ALLOC], sb.n_op[OP_FREE], sb.n_op[OP_NONE]);
        $display("responses: %0d ok, %0d no fit, %0d table full, %0d not found",
                 sb.n_st[ST_OK], sb.n_st[ST_NO_FIT], sb.n_st[ST_FULL], sb.n_st[ST_NOT_FOUND]);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
